FILE: design/pre_pkg.sv
`default_nettype none
package pre_pkg;

  localparam int FRAMES     = 8;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int NUM_W      = $clog2(FRAMES + 1);
  localparam int PAGE_BITS  = 8;
  localparam int PAGES      = 1 << PAGE_BITS;
  localparam int COUNT_BITS = 16;
  localparam int FAULT_BITS = 16;
  localparam int CFG_W      = 4;

  typedef enum logic [1:0] {
    MODE_FIFO  = 2'd0,
    MODE_CLOCK = 2'd1,
    MODE_LFU   = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef enum logic {
    REG_POLICY = 1'b0,
    REG_FRAMES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic clock_step;
    logic scan_step;
    logic load;
    logic clr_step;
  } pre_cmd_t;

  typedef struct packed {
    logic  hit;
    mode_t mode;
    logic  mark_set;
    logic  scan_done;
    logic  clr_done;
  } pre_sts_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: design/page_replacement_engine.sv
// Page replacement engine.
// Input channel: in_valid / in_stall carry one page reference (in_page_number).
// Output channel: out_valid / out_stall carry one result per reference: hit,
// frame index, displaced page and the saturating fault total.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 policy mode, 1 active frame count); write only while idle.
// One request is in flight at a time; in_stall is high from acceptance until
// its result is taken.
// Steps: a hit goes from lookup to the result; a FIFO or second chance
// fault steps the hand (second chance clears each marked frame it passes,
// up to active frames), then loads; an LFU fault scans for the minimum, then
// loads. The clock sweep and the LFU scan examine one frame per cycle.
// Reset: frames empty, ranks in frame index order, then a pass over all 256
// entries clears the per-page count memory, during which in_stall stays high.
// When out_stall is high the result holds on the outputs and no new request
// is accepted.
`default_nettype none
module page_replacement_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [pre_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pre_pkg::PAGE_BITS-1:0] in_page_number,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [pre_pkg::FRAME_W-1:0]        out_frame_index,
  output logic                               out_evicted_valid,
  output logic [pre_pkg::PAGE_BITS-1:0]      out_evicted_page,
  output logic [pre_pkg::FAULT_BITS-1:0]     out_fault_total
);

  pre_pkg::pre_cmd_t cmd;
  pre_pkg::pre_sts_t sts;

  pre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pre_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_page_number    (in_page_number),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
`default_nettype wire

FILE: design/pre_ram.sv
`default_nettype none
module pre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/pre_ctrl.sv
`default_nettype none
module pre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire pre_pkg::pre_sts_t sts,
  output pre_pkg::pre_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_CLOCK = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_LOAD  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK: begin
        if (sts.hit) state_nxt = S_OUT;
        else if (sts.mode == pre_pkg::MODE_LFU) state_nxt = S_SCAN;
        else state_nxt = S_CLOCK;
      end
      S_CLOCK: if (!sts.mark_set) state_nxt = S_LOAD;
      S_SCAN:  if (sts.scan_done) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign cmd.accept     = (state_r == S_IDLE) && in_valid;
  assign cmd.look       = (state_r == S_LOOK);
  assign cmd.clock_step = (state_r == S_CLOCK);
  assign cmd.scan_step  = (state_r == S_SCAN);
  assign cmd.load       = (state_r == S_LOAD);
  assign cmd.clr_step   = (state_r == S_CLR);

endmodule
`default_nettype wire

FILE: design/pre_dp.sv
`default_nettype none
module pre_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [pre_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [pre_pkg::PAGE_BITS-1:0]    in_page_number,
  output logic                                  out_hit,
  output logic [pre_pkg::FRAME_W-1:0]           out_frame_index,
  output logic                                  out_evicted_valid,
  output logic [pre_pkg::PAGE_BITS-1:0]         out_evicted_page,
  output logic [pre_pkg::FAULT_BITS-1:0]        out_fault_total,
  input  wire pre_pkg::pre_cmd_t                cmd,
  output pre_pkg::pre_sts_t                     sts
);

  localparam int FR = pre_pkg::FRAMES;
  localparam int FW = pre_pkg::FRAME_W;
  localparam int NW = pre_pkg::NUM_W;
  localparam int PB = pre_pkg::PAGE_BITS;
  localparam int CB = pre_pkg::COUNT_BITS;

  logic [1:0]    pol_r;
  logic [3:0]    act_r;
  logic [NW-1:0] n_cur;
  pre_pkg::mode_t mode_cur;

  logic [PB-1:0] frame_page_r [FR];
  logic [FR-1:0] frame_valid_r;
  logic [CB-1:0] use_mark_r [FR];
  logic [FW-1:0] age_r [FR];
  logic [FW-1:0] hand_r;
  logic [pre_pkg::FAULT_BITS-1:0] fault_r;

  logic [PB-1:0]  page_r;
  logic [NW-1:0]  n_r;
  pre_pkg::mode_t mode_r;
  logic [CB-1:0]  cnt_r;
  logic [FW-1:0]  victim_r, best_r;
  logic [CB-1:0]  low_r;
  logic [NW-1:0]  idx_r;
  logic           hit_r;
  logic [PB-1:0]  clr_r;

  logic           found;
  logic [FW-1:0]  found_idx;
  logic [FW-1:0]  hand_eff;
  logic [FW-1:0]  hand_inc;
  logic [FW-1:0]  vic;
  logic [FW-1:0]  scan_i;
  logic [FW-1:0]  old_rank;
  logic [FW-1:0]  top_rank;
  logic [CB-1:0]  rdata;
  logic [CB-1:0]  cnt_new;
  logic           ram_we;
  logic [PB-1:0]  ram_waddr;
  logic [CB-1:0]  ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= 2'd0;
      act_r <= 4'd5;
    end else if (cfg_we) begin
      unique case (pre_pkg::reg_idx_t'(cfg_index))
        pre_pkg::REG_POLICY: pol_r <= cfg_data[1:0];
        pre_pkg::REG_FRAMES: act_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (act_r == 4'd0) n_cur = NW'(1);
    else if (NW'(act_r) > NW'(FR)) n_cur = NW'(FR);
    else n_cur = NW'(act_r);
    mode_cur = (pol_r == pre_pkg::MODE_SPARE) ? pre_pkg::MODE_FIFO : pre_pkg::mode_t'(pol_r);
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = FR - 1; i >= 0; i--) begin
      if (NW'(i) < n_r && frame_valid_r[i] && frame_page_r[i] == page_r) begin
        found     = 1'b1;
        found_idx = FW'(i);
      end
    end
  end

  assign hand_eff = (NW'(hand_r) >= n_r) ? '0 : hand_r;
  assign hand_inc = (NW'(hand_r) + 1'b1 < n_r) ? hand_r + 1'b1 : '0;
  assign vic      = (mode_r == pre_pkg::MODE_LFU) ? best_r : victim_r;
  assign scan_i   = idx_r[FW-1:0];
  assign old_rank = age_r[vic];
  assign top_rank = FW'(n_r - 1'b1);
  assign cnt_new  = pre_pkg::sat_inc(rdata);

  assign ram_we    = cmd.clr_step || (cmd.look && mode_r == pre_pkg::MODE_LFU);
  assign ram_waddr = cmd.clr_step ? clr_r : page_r;
  assign ram_wdata = cmd.clr_step ? '0 : cnt_new;

  pre_ram #(.WIDTH(CB), .DEPTH(pre_pkg::PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_page_number),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      hand_r        <= '0;
      fault_r       <= '0;
      for (int i = 0; i < FR; i++) begin
        frame_page_r[i] <= '0;
        use_mark_r[i]   <= '0;
        age_r[i]        <= FW'(i);
      end
    end else begin
      if (cmd.look) begin
        if (found) begin
          if (mode_r == pre_pkg::MODE_CLOCK) use_mark_r[found_idx] <= CB'(1);
          else if (mode_r == pre_pkg::MODE_LFU)
            use_mark_r[found_idx] <= pre_pkg::sat_inc(use_mark_r[found_idx]);
        end else begin
          hand_r <= hand_eff;
        end
      end
      if (cmd.clock_step) begin
        if (sts.mark_set) use_mark_r[hand_r] <= '0;
        hand_r <= hand_inc;
      end
      if (cmd.load) begin
        frame_page_r[vic]  <= page_r;
        frame_valid_r[vic] <= 1'b1;
        use_mark_r[vic]    <= (mode_r == pre_pkg::MODE_LFU) ? cnt_r : '0;
        if (fault_r != {pre_pkg::FAULT_BITS{1'b1}}) fault_r <= fault_r + 1'b1;
        if (mode_r == pre_pkg::MODE_LFU) begin
          for (int i = 0; i < FR; i++) begin
            if (FW'(i) == vic) age_r[i] <= top_rank;
            else if (NW'(i) < n_r && old_rank < age_r[i]) age_r[i] <= age_r[i] - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= in_page_number;
      n_r    <= n_cur;
      mode_r <= mode_cur;
    end
    if (cmd.look) begin
      hit_r    <= found;
      victim_r <= found_idx;
      cnt_r    <= cnt_new;
      best_r   <= '0;
      low_r    <= use_mark_r[0];
      idx_r    <= NW'(1);
    end
    if (cmd.clock_step && !sts.mark_set) begin
      victim_r <= hand_r;
    end
    if (cmd.scan_step && !sts.scan_done) begin
      if (use_mark_r[scan_i] < low_r) begin
        low_r  <= use_mark_r[scan_i];
        best_r <= scan_i;
      end else if (use_mark_r[scan_i] == low_r && age_r[scan_i] < age_r[best_r]) begin
        best_r <= scan_i;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.look && found) begin
      out_hit           <= 1'b1;
      out_frame_index   <= found_idx;
      out_evicted_valid <= 1'b0;
      out_evicted_page  <= '0;
      out_fault_total   <= fault_r;
    end
    if (cmd.load) begin
      out_hit           <= 1'b0;
      out_frame_index   <= vic;
      out_evicted_valid <= frame_valid_r[vic];
      out_evicted_page  <= frame_valid_r[vic] ? frame_page_r[vic] : '0;
      out_fault_total   <= (fault_r != {pre_pkg::FAULT_BITS{1'b1}}) ? fault_r + 1'b1 : fault_r;
    end
  end

  assign sts.hit       = found;
  assign sts.mode      = mode_r;
  assign sts.mark_set  = (mode_r == pre_pkg::MODE_CLOCK) && (use_mark_r[hand_r] != '0);
  assign sts.scan_done = (idx_r >= n_r);
  assign sts.clr_done  = (clr_r == {PB{1'b1}});

  a_scan_lfu: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> mode_r == pre_pkg::MODE_LFU)
    else $error("scan outside LFU mode");

  a_fault_up: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> fault_r != '0 && fault_r >= $past(fault_r))
    else $error("fault total did not advance");

  a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> frame_valid_r[$past(vic)] && frame_page_r[$past(vic)] == page_r)
    else $error("victim frame not loaded");

  a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.look |=> hit_r == $past(found))
    else $error("hit flag mismatch");

endmodule
`default_nettype wire
